FILE: hw/rtl/xm1k_pkg.sv
// Package for the XMODEM-1K receiver: result kinds, line codes, modes,
// result record type, register indices and the CRC-16 step. No dependencies.
package xm1k_pkg;
  localparam logic [7:0] C_SOH  = 8'h01;
  localparam logic [7:0] C_STX  = 8'h02;
  localparam logic [7:0] C_EOT  = 8'h04;
  localparam logic [7:0] C_ACK  = 8'h06;
  localparam logic [7:0] C_NAK  = 8'h15;
  localparam logic [7:0] C_CAN  = 8'h18;
  localparam logic [7:0] C_POLL = 8'h43;
  localparam logic [31:0] FIRST_TAIL = 32'h5A435A43;
  localparam logic [23:0] MAX24 = 24'hFFFFFF;
  localparam int unsigned LONG_PAYLOAD = 1024;
  localparam int unsigned SHORT_PAYLOAD = 128;

  localparam logic [2:0] K_SEND    = 3'd0;
  localparam logic [2:0] K_PAYLOAD = 3'd1;
  localparam logic [2:0] K_COMMIT  = 3'd2;
  localparam logic [2:0] K_DISCARD = 3'd3;
  localparam logic [2:0] K_FINISH  = 3'd4;

  localparam logic [1:0] O_OK   = 2'd0;
  localparam logic [1:0] O_NONE = 2'd1;
  localparam logic [1:0] O_ERR  = 2'd2;

  localparam logic [2:0] R_POLL  = 3'd0;
  localparam logic [2:0] R_SETUP = 3'd1;
  localparam logic [2:0] R_FIRST = 3'd2;
  localparam logic [2:0] R_CHAR  = 3'd3;
  localparam logic [2:0] R_RETRY = 3'd4;

  typedef enum logic [3:0] {
    M_POLL = 4'b0001,
    M_WAIT = 4'b0010,
    M_RECV = 4'b0100,
    M_DONE = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic [1:0] outcome;
  } res_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction
endpackage

FILE: hw/rtl/xm1k_if.sv
// Word channels for the XMODEM-1K receiver.
// Depends on nothing.
interface xm1k_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;
  modport source (output valid, func, rx_byte, input ready);
  modport sink (input valid, func, rx_byte, output ready);
endinterface

interface xm1k_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] value;
  logic [1:0] outcome;
  logic       last;
  modport source (output valid, kind, value, outcome, last, input ready);
  modport sink (input valid, kind, value, outcome, last, output ready);
endinterface

FILE: hw/rtl/xmodem_1k_receiver.sv
// XMODEM-1K CRC receiver top level: protocol step and result queue.
// Depends on xm1k_pkg and the channel interfaces in xm1k_if.sv.
//
// channel | dir | word
// in      | in  | func, rx_byte
// out     | out | kind, value, outcome, last
// apb     | in  | 5 config registers at 4*i
//
// One word is stepped per cycle; it yields up to three results that go into
// a 4-deep queue (one extra slot). Input is taken while the queue has room
// for three more, so with the output taken every cycle a word that makes one
// result flows back to back; words that make several results drain at one
// result per cycle. Synchronous reset clears state and queue.
module xmodem_1k_receiver
  import xm1k_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  xm1k_in_if.sink     in_ch,
  xm1k_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [23:0] poll_interval_ticks, session_wait_ticks;
  logic [15:0] first_byte_timeout, char_timeout;
  logic [3:0]  retry_limit;
  logic [2:0]  reg_idx;
  assign reg_idx = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_interval_ticks <= 24'd1000;
      session_wait_ticks <= 24'd3000;
      first_byte_timeout <= 16'd100;
      char_timeout <= 16'd2;
      retry_limit <= 4'd5;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (reg_idx)
        R_POLL:  poll_interval_ticks <= pwdata[23:0];
        R_SETUP: session_wait_ticks <= pwdata[23:0];
        R_FIRST: first_byte_timeout <= pwdata[15:0];
        R_CHAR:  char_timeout <= pwdata[15:0];
        R_RETRY: retry_limit <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      R_POLL:  prdata = {8'd0, poll_interval_ticks};
      R_SETUP: prdata = {8'd0, session_wait_ticks};
      R_FIRST: prdata = {16'd0, first_byte_timeout};
      R_CHAR:  prdata = {16'd0, char_timeout};
      R_RETRY: prdata = {28'd0, retry_limit};
      default: prdata = 32'd0;
    endcase
  end

  // protocol state
  mode_t       mode, mode_next;
  logic [10:0] byte_count, byte_count_next;
  logic        long_packet, long_packet_next;
  logic [7:0]  header_control, header_control_next;
  logic [7:0]  header_index, header_index_next;
  logic [7:0]  header_complement, header_complement_next;
  logic [7:0]  expected_index, expected_index_next;
  logic [3:0]  timeout_count, timeout_count_next;
  logic [3:0]  error_count, error_count_next;
  logic [23:0] session_timer, session_timer_next;
  logic [23:0] idle_timer, idle_timer_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] received_crc, received_crc_next;
  logic [31:0] tail_bytes, tail_bytes_next;
  logic        flash_changed, flash_changed_next;

  res_t        res [3];
  logic [1:0]  nres;

  logic        take;
  logic [2:0]  q_cnt;
  assign in_ch.ready = (q_cnt <= 3'd1);
  assign take = in_ch.valid && in_ch.ready;

  always_comb begin
    logic [7:0]  b;
    logic [10:0] len3;
    logic [15:0] limit;
    logic [23:0] itmp, stmp;
    logic [3:0]  ec;
    logic        do_fault, started, do_poll;
    b = in_ch.rx_byte;
    mode_next = mode;
    byte_count_next = byte_count;
    long_packet_next = long_packet;
    header_control_next = header_control;
    header_index_next = header_index;
    header_complement_next = header_complement;
    expected_index_next = expected_index;
    timeout_count_next = timeout_count;
    error_count_next = error_count;
    session_timer_next = session_timer;
    idle_timer_next = idle_timer;
    running_crc_next = running_crc;
    received_crc_next = received_crc;
    tail_bytes_next = tail_bytes;
    flash_changed_next = flash_changed;
    for (int i = 0; i < 3; i++) res[i] = '0;
    nres = 2'd0;
    len3 = long_packet ? 11'(LONG_PAYLOAD + 3) : 11'(SHORT_PAYLOAD + 3);
    limit = (byte_count == 11'd0) ? first_byte_timeout : char_timeout;
    itmp = idle_timer;
    stmp = session_timer;
    ec = error_count;
    do_fault = 1'b0;
    started = 1'b0;
    do_poll = 1'b0;
    case (mode)
      M_POLL: begin
        if (!in_ch.func && stmp != MAX24) stmp = stmp + 24'd1;
        session_timer_next = stmp;
        do_poll = 1'b1;
      end
      M_WAIT: begin
        if (in_ch.func) begin
          if (b == C_SOH || b == C_STX) begin
            header_control_next = b;
            long_packet_next = (b == C_STX);
            running_crc_next = '0;
            tail_bytes_next = '0;
            byte_count_next = 11'd1;
            idle_timer_next = '0;
            mode_next = M_RECV;
          end else do_poll = 1'b1;
        end else begin
          if (stmp != MAX24) stmp = stmp + 24'd1;
          if (itmp != MAX24) itmp = itmp + 24'd1;
          session_timer_next = stmp;
          idle_timer_next = itmp;
          do_poll = (itmp >= poll_interval_ticks);
        end
      end
      M_RECV: begin
        if (in_ch.func) begin
          timeout_count_next = '0;
          idle_timer_next = '0;
          if (byte_count == 11'd0) begin
            if (b == C_EOT) begin
              header_control_next = b;
              res[0] = '{K_SEND, C_ACK, O_OK};
              res[1] = '{K_FINISH, 8'd0, O_OK};
              nres = 2'd2;
              mode_next = M_DONE;
            end else begin
              header_control_next = b;
              long_packet_next = (b == C_STX);
              running_crc_next = '0;
              tail_bytes_next = '0;
              byte_count_next = 11'd1;
            end
          end else if (byte_count == 11'd1) begin
            header_index_next = b;
            byte_count_next = 11'd2;
          end else if (byte_count == 11'd2) begin
            header_complement_next = b;
            byte_count_next = 11'd3;
          end else if (byte_count < len3) begin
            running_crc_next = crc_step(running_crc, b);
            tail_bytes_next = {tail_bytes[23:0], b};
            res[0] = '{K_PAYLOAD, b, O_OK};
            nres = 2'd1;
            byte_count_next = byte_count + 11'd1;
          end else if (byte_count == len3) begin
            received_crc_next = {b, 8'd0};
            byte_count_next = byte_count + 11'd1;
          end else begin
            received_crc_next = {received_crc[15:8], b};
            if (header_control != (long_packet ? C_STX : C_SOH) ||
                8'(header_index + header_complement) != 8'hFF) begin
              do_fault = 1'b1;
              started = 1'b1;
              if (ec != 4'd15) ec = ec + 4'd1;
            end else if (header_index == 8'(expected_index - 8'd1)) begin
              res[0] = '{K_DISCARD, 8'd0, O_OK};
              res[1] = '{K_SEND, C_ACK, O_OK};
              nres = 2'd2;
              ec = '0;
              byte_count_next = '0;
            end else if (header_index != expected_index ||
                         running_crc != {received_crc[15:8], b}) begin
              do_fault = 1'b1;
              started = 1'b1;
              if (ec != 4'd15) ec = ec + 4'd1;
            end else if (!flash_changed && (!long_packet || tail_bytes != FIRST_TAIL)) begin
              res[0] = '{K_DISCARD, 8'd0, O_OK};
              res[1] = '{K_FINISH, 8'd0, O_NONE};
              nres = 2'd2;
              mode_next = M_DONE;
            end else begin
              flash_changed_next = 1'b1;
              res[0] = '{K_COMMIT, 8'd0, O_OK};
              res[1] = '{K_SEND, C_ACK, O_OK};
              nres = 2'd2;
              expected_index_next = expected_index + 8'd1;
              ec = '0;
              byte_count_next = '0;
            end
            error_count_next = ec;
          end
        end else begin
          if (itmp != MAX24) itmp = itmp + 24'd1;
          idle_timer_next = itmp;
          if (itmp >= {8'd0, limit}) begin
            idle_timer_next = '0;
            timeout_count_next = (timeout_count != 4'd15) ? timeout_count + 4'd1
                                                          : timeout_count;
            do_fault = 1'b1;
            started = (byte_count != 11'd0);
          end
        end
        if (do_fault) begin
          if (started) begin
            res[0] = '{K_DISCARD, 8'd0, O_OK};
          end
          if (ec >= retry_limit || timeout_count_next >= retry_limit) begin
            res[{1'b0, started}] = '{K_SEND, C_CAN, O_OK};
            res[started ? 2'd2 : 2'd1] = '{K_FINISH, 8'd0, flash_changed ? O_ERR : O_NONE};
            nres = started ? 2'd3 : 2'd2;
            mode_next = M_DONE;
          end else begin
            res[{1'b0, started}] = '{K_SEND, C_NAK, O_OK};
            nres = started ? 2'd2 : 2'd1;
            byte_count_next = '0;
          end
        end
      end
      default: ;
    endcase
    if (do_poll) begin
      if (stmp >= session_wait_ticks) begin
        res[0] = '{K_FINISH, 8'd0, O_NONE};
        mode_next = M_DONE;
      end else begin
        res[0] = '{K_SEND, C_POLL, O_OK};
        idle_timer_next = '0;
        mode_next = M_WAIT;
      end
      nres = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_POLL;
      byte_count <= '0;
      long_packet <= 1'b0;
      header_control <= '0;
      header_index <= '0;
      header_complement <= '0;
      expected_index <= 8'd1;
      timeout_count <= '0;
      error_count <= '0;
      session_timer <= '0;
      idle_timer <= '0;
      running_crc <= '0;
      received_crc <= '0;
      tail_bytes <= '0;
      flash_changed <= 1'b0;
    end else if (take) begin
      mode <= mode_next;
      byte_count <= byte_count_next;
      long_packet <= long_packet_next;
      header_control <= header_control_next;
      header_index <= header_index_next;
      header_complement <= header_complement_next;
      expected_index <= expected_index_next;
      timeout_count <= timeout_count_next;
      error_count <= error_count_next;
      session_timer <= session_timer_next;
      idle_timer <= idle_timer_next;
      running_crc <= running_crc_next;
      received_crc <= received_crc_next;
      tail_bytes <= tail_bytes_next;
      flash_changed <= flash_changed_next;
    end
  end

  // result queue, 4 slots, entries are {res, last}
  logic [13:0] q_mem [4];
  logic [1:0]  q_rd, q_wr;
  logic        pop;
  logic [2:0]  q_cnt_next;
  assign pop = out_ch.valid && out_ch.ready;
  assign out_ch.valid = (q_cnt != 3'd0);
  assign {out_ch.kind, out_ch.value, out_ch.outcome, out_ch.last} = q_mem[q_rd];

  always_comb begin
    q_cnt_next = q_cnt - {2'd0, pop};
    if (take) q_cnt_next = q_cnt_next + {1'b0, nres};
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < nres) q_mem[2'(q_wr + 2'(i))] <= {res[i], (2'(i) == nres - 2'd1)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_rd <= '0;
      q_wr <= '0;
      q_cnt <= '0;
    end else begin
      if (pop) q_rd <= q_rd + 2'd1;
      if (take) q_wr <= q_wr + nres;
      q_cnt <= q_cnt_next;
    end
  end

  a_qcap: assert property (@(posedge clk) disable iff (rst) q_cnt <= 3'd4)
    else $error("result queue overflow");
  a_done: assert property (@(posedge clk) disable iff (rst)
    mode == M_DONE |=> mode == M_DONE)
    else $error("left done mode");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    !take && !pop |=> $stable(q_cnt))
    else $error("queue count moved");
endmodule

FILE: tb/sv/tb_xmodem_1k_receiver.sv
// Self-checking testbench for xmodem_1k_receiver: polling, packet framing, faults, timeouts.
// It runs a predictor against the output stream with random idles and a long output hold-off.
// Depends on xm1k_pkg, xm1k_if.sv and the RTL top level.
module tb_xmodem_1k_receiver;
  import xm1k_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    res_t r;
    logic last;
  } xm_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  xm1k_in_if  in_ch();
  xm1k_out_if out_ch();

  xmodem_1k_receiver i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // predictor state and register copies
  mode_t       st_mode;
  int unsigned byte_cnt;
  bit          long_pkt, flashed;
  logic [7:0]  hdr_ctrl, hdr_idx, hdr_cmp, exp_idx;
  logic [3:0]  tmo_cnt, err_cnt;
  logic [23:0] sess_tmr, idle_tmr;
  logic [15:0] crc_acc, crc_rx;
  logic [31:0] tail;
  logic [23:0] cfg_poll, cfg_sess;
  logic [15:0] cfg_first, cfg_char;
  logic [3:0]  cfg_retry;

  xm_res_t expected_q[$];
  xm_res_t step_q[$];

  int mismatches = 0;
  int words_in = 0, words_out = 0, commits = 0, discards = 0;
  int send_idle_pct = 0, recv_idle_pct = 0, tick_pct = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  logic [7:0] next_idx = 8'd1;
  bit ended_by_eot;

  function automatic logic [15:0] crc16_upd(logic [15:0] c, logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) x = x[15] ? {x[14:0], 1'b0} ^ 16'h1021 : {x[14:0], 1'b0};
    return x;
  endfunction

  function automatic void push_res(logic [2:0] k, logic [7:0] v, logic [1:0] o);
    xm_res_t e;
    e.r.kind = k;
    e.r.value = v;
    e.r.outcome = o;
    e.last = 1'b0;
    step_q.push_back(e);
    if (k == K_COMMIT) commits++;
    if (k == K_DISCARD) discards++;
  endfunction

  function automatic void session_end(logic [1:0] o);
    push_res(K_FINISH, 8'h00, o);
    st_mode = M_DONE;
  endfunction

  function automatic void poll_again();
    if (sess_tmr >= cfg_sess) session_end(O_NONE);
    else begin
      push_res(K_SEND, C_POLL, O_OK);
      idle_tmr = '0;
      st_mode = M_WAIT;
    end
  endfunction

  function automatic void open_packet(logic [7:0] c);
    hdr_ctrl = c;
    long_pkt = (c == C_STX);
    crc_acc = '0;
    tail = '0;
    byte_cnt = 1;
  endfunction

  function automatic void reject(bit started);
    if (started) push_res(K_DISCARD, 8'h00, O_OK);
    if (err_cnt >= cfg_retry || tmo_cnt >= cfg_retry) begin
      push_res(K_SEND, C_CAN, O_OK);
      session_end(flashed ? O_ERR : O_NONE);
    end else begin
      push_res(K_SEND, C_NAK, O_OK);
      byte_cnt = 0;
    end
  endfunction

  function automatic void bump_err();
    if (err_cnt != 4'hF) err_cnt++;
  endfunction

  function automatic void close_packet();
    if (hdr_ctrl != (long_pkt ? C_STX : C_SOH) ||
        ({1'b0, hdr_idx} + {1'b0, hdr_cmp}) != 9'h0FF) begin
      bump_err();
      reject(1);
    end else if (hdr_idx == exp_idx - 8'd1) begin
      push_res(K_DISCARD, 8'h00, O_OK);
      push_res(K_SEND, C_ACK, O_OK);
      err_cnt = '0;
      byte_cnt = 0;
    end else if (hdr_idx != exp_idx || crc_acc != crc_rx) begin
      bump_err();
      reject(1);
    end else if (!flashed && (!long_pkt || tail != FIRST_TAIL)) begin
      push_res(K_DISCARD, 8'h00, O_OK);
      session_end(O_NONE);
    end else begin
      flashed = 1;
      push_res(K_COMMIT, 8'h00, O_OK);
      push_res(K_SEND, C_ACK, O_OK);
      exp_idx++;
      err_cnt = '0;
      byte_cnt = 0;
    end
  endfunction

  function automatic void take_byte(logic [7:0] b);
    int unsigned len;
    len = long_pkt ? LONG_PAYLOAD : SHORT_PAYLOAD;
    tmo_cnt = '0;
    idle_tmr = '0;
    if (byte_cnt == 0) begin
      if (b == C_EOT) begin
        hdr_ctrl = b;
        push_res(K_SEND, C_ACK, O_OK);
        session_end(O_OK);
      end else open_packet(b);
      return;
    end
    if (byte_cnt == 1) hdr_idx = b;
    else if (byte_cnt == 2) hdr_cmp = b;
    else if (byte_cnt < 3 + len) begin
      crc_acc = crc16_upd(crc_acc, b);
      tail = {tail[23:0], b};
      push_res(K_PAYLOAD, b, O_OK);
    end else if (byte_cnt == 3 + len) crc_rx = {b, 8'h00};
    else begin
      crc_rx[7:0] = b;
      close_packet();
      return;
    end
    byte_cnt++;
  endfunction

  function automatic void predict_word(logic f, logic [7:0] b);
    logic [15:0] lim;
    step_q.delete();
    case (st_mode)
      M_POLL: begin
        if (!f && sess_tmr != MAX24) sess_tmr++;
        poll_again();
      end
      M_WAIT: begin
        if (f) begin
          if (b == C_SOH || b == C_STX) begin
            open_packet(b);
            idle_tmr = '0;
            st_mode = M_RECV;
          end else poll_again();
        end else begin
          if (sess_tmr != MAX24) sess_tmr++;
          if (idle_tmr != MAX24) idle_tmr++;
          if (idle_tmr >= cfg_poll) poll_again();
        end
      end
      M_RECV: begin
        if (f) take_byte(b);
        else begin
          lim = (byte_cnt == 0) ? cfg_first : cfg_char;
          if (idle_tmr != MAX24) idle_tmr++;
          if (idle_tmr >= lim) begin
            idle_tmr = '0;
            if (tmo_cnt != 4'hF) tmo_cnt++;
            reject(byte_cnt != 0);
          end
        end
      end
      default: ;
    endcase
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  // input prediction first, so a same-edge result always finds its expectation
  always @(posedge clk) begin
    xm_res_t e;
    if (!rst) begin
      stall_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        predict_word(in_ch.func, in_ch.rx_byte);
        words_in++;
        stall_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        words_out++;
        stall_cycles = 0;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: kind %0d value %02h outcome %0d last %0b",
                     out_ch.kind, out_ch.value, out_ch.outcome, out_ch.last);
        end else begin
          e = expected_q.pop_front();
          if (out_ch.kind !== e.r.kind || out_ch.value !== e.r.value ||
              out_ch.outcome !== e.r.outcome || out_ch.last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected %0d/%02h/%0d/%0b got %0d/%02h/%0d/%0b",
                       words_out, e.r.kind, e.r.value, e.r.outcome, e.last,
                       out_ch.kind, out_ch.value, out_ch.outcome, out_ch.last);
          end
        end
      end
      if (stall_cycles >= 5000) begin
        $display("watchdog: no word moved for %0d cycles", stall_cycles);
        $display("xmodem_1k_receiver verification failed");
        $finish;
      end
    end
  end

  // output side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_word(logic f, logic [7:0] b);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_tick();
    send_word(1'b0, 8'($urandom));
  endtask

  // whole or cut-short packet; ticks may fall between bytes
  task automatic send_packet(logic [7:0] ctrl, logic [7:0] idx, logic [7:0] cmp,
                             bit bad_crc, bit magic_tail, int cut);
    int unsigned len, total;
    logic [15:0] crc;
    logic [7:0] b;
    len = (ctrl == C_STX) ? LONG_PAYLOAD : SHORT_PAYLOAD;
    total = len + 5;
    if (cut > 0) total = cut;
    crc = '0;
    for (int unsigned i = 0; i < total; i++) begin
      if (tick_pct > 0 && $urandom_range(99) < tick_pct) send_tick();
      if (i == 0) b = ctrl;
      else if (i == 1) b = idx;
      else if (i == 2) b = cmp;
      else if (i < 3 + len) begin
        b = 8'($urandom);
        if (magic_tail && i >= len - 1) b = FIRST_TAIL[8 * (len + 2 - i) +: 8];
        crc = crc16_upd(crc, b);
      end else if (i == 3 + len) b = crc[15:8];
      else b = crc[7:0] ^ {7'd0, bad_crc};
      send_word(1'b1, b);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    logic [31:0] mask;
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
    case (idx)
      R_POLL:  begin cfg_poll = v[23:0];  mask = 32'hFFFFFF; end
      R_SETUP: begin cfg_sess = v[23:0];  mask = 32'hFFFFFF; end
      R_FIRST: begin cfg_first = v[15:0]; mask = 32'hFFFF; end
      R_CHAR:  begin cfg_char = v[15:0];  mask = 32'hFFFF; end
      default: begin cfg_retry = v[3:0];  mask = 32'hF; end
    endcase
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
    if ((prdata & mask) !== (v & mask)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d reads %08h, wrote %08h", idx, prdata, v);
    end
  endtask

  task automatic test_polling();
    reg_write(R_POLL, 32'd3);
    reg_write(R_SETUP, 32'hFFFFFF);
    reg_write(R_FIRST, 32'd65535);
    reg_write(R_CHAR, 32'd65535);
    reg_write(R_RETRY, 32'd15);
    send_word(1'b1, 8'hFF);      // dropped while polling
    repeat (5) send_tick();      // poll, then re-poll once the interval runs out
    send_word(1'b1, 8'h00);      // stray bytes force a fresh poll
    send_word(1'b1, C_EOT);
    send_word(1'b1, 8'hFF);
    drain();
    reg_write(R_POLL, 32'd0);
    repeat (3) send_tick();      // zero interval: every tick polls
    drain();
    reg_write(R_POLL, 32'hFFFFFF);
  endtask

  task automatic test_first_packet();
    send_packet(C_STX, 8'd1, 8'hFE, 0, 1, 0);
    next_idx = 8'd2;
    send_packet(C_SOH, 8'd1, 8'hFE, 0, 0, 0);   // duplicate of the first one
    drain();
  endtask

  task automatic test_faults();
    send_packet(8'h00, next_idx, ~next_idx, 0, 0, 0);          // bad control byte
    send_packet(C_SOH, next_idx, next_idx, 0, 0, 0);           // bad complement
    send_packet(C_SOH, next_idx + 8'd3, ~(next_idx + 8'd3), 0, 0, 0);  // out of sequence
    send_packet(C_SOH, next_idx, ~next_idx, 1, 0, 0);          // crc error
    send_packet(C_SOH, next_idx, ~next_idx, 0, 0, 0);
    next_idx++;
    drain();
    reg_write(R_FIRST, 32'd1);
    reg_write(R_CHAR, 32'd1);
    send_tick();                                    // no first byte in time
    send_packet(C_SOH, next_idx, ~next_idx, 0, 0, 10);
    send_tick();                                    // gap inside a packet
    drain();
    reg_write(R_FIRST, 32'd65535);
    reg_write(R_CHAR, 32'd65535);
  endtask

  task automatic run_traffic(int n_words);
    int start, r, faults_in_row;
    logic [7:0] c;
    start = words_in;
    faults_in_row = 0;
    tick_pct = 3;
    while (words_in - start < n_words) begin
      r = $urandom_range(99);
      if (r < 60 || faults_in_row >= 3) begin
        send_packet(C_SOH, next_idx, ~next_idx, 0, 0, 0);
        next_idx++;
        faults_in_row = 0;
      end else if (r < 72) begin
        send_packet(C_SOH, next_idx - 8'd1, ~(next_idx - 8'd1), 0, 0, 0);
        faults_in_row = 0;
      end else if (r < 90) begin
        faults_in_row++;
        case ($urandom_range(3))
          0: begin
            do c = 8'($urandom); while (c == C_SOH || c == C_STX || c == C_EOT);
            send_packet(c, next_idx, ~next_idx, 0, 0, 0);
          end
          // complement is never the right one
          1: send_packet(C_SOH, next_idx, 8'($urandom_range(254)) ^ next_idx, 0, 0, 0);
          2: send_packet(C_SOH, next_idx + 8'($urandom_range(1, 254)), 8'($urandom), 0, 0, 0);
          default: send_packet(C_SOH, next_idx, ~next_idx, 1, 0, 0);
        endcase
      end else repeat ($urandom_range(1, 6)) send_tick();
    end
    tick_pct = 0;
    drain();
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 38; recv_idle_pct = 76;
    run_traffic(150);
    send_idle_pct = 76; recv_idle_pct = 38;
    run_traffic(150);
    send_idle_pct = 0; recv_idle_pct = 0;
    hold_left = 400;     // output blocked while words are offered; input stalls once the queue fills
    run_traffic(150);
  endtask

  task automatic test_session_end();
    ended_by_eot = $urandom_range(1);
    if (ended_by_eot) send_word(1'b1, C_EOT);
    else begin
      drain();
      reg_write(R_RETRY, 32'd1);
      send_packet(C_SOH, next_idx, ~next_idx, 1, 0, 0);   // cancel on first fault
    end
    repeat (4) send_tick();      // ignored once done
    send_word(1'b1, C_SOH);
    drain();
    reg_write(R_SETUP, 32'd0);
    reg_write(R_POLL, 32'd0);
  endtask

  initial begin
    in_ch.valid <= 1'b0; in_ch.func <= 1'b0; in_ch.rx_byte <= 8'h00;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    st_mode = M_POLL; byte_cnt = 0; long_pkt = 0; flashed = 0;
    hdr_ctrl = '0; hdr_idx = '0; hdr_cmp = '0; exp_idx = 8'd1;
    tmo_cnt = '0; err_cnt = '0; sess_tmr = '0; idle_tmr = '0;
    crc_acc = '0; crc_rx = '0; tail = '0;
    cfg_poll = 24'd1000; cfg_sess = 24'd3000; cfg_first = 16'd100;
    cfg_char = 16'd2; cfg_retry = 4'd5;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_polling();
    test_first_packet();
    test_faults();
    test_random_traffic();
    test_session_end();
    repeat (20) @(posedge clk);
    $display("covered: polling, 1K first packet, duplicates, header/seq/crc faults, timeouts");
    $display("%0d words in, %0d results, %0d commits, %0d discards, ended by %s",
             words_in, words_out, commits, discards, ended_by_eot ? "EOT" : "cancel");
    if (mismatches == 0 && expected_q.size() == 0)
      $display("xmodem_1k_receiver verification clean");
    else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, expected_q.size());
      $display("xmodem_1k_receiver verification failed");
    end
    $finish;
  end
endmodule

FILE: xmodem_1k_receiver.f
hw/rtl/xm1k_pkg.sv
hw/rtl/xm1k_if.sv
hw/rtl/xmodem_1k_receiver.sv
tb/sv/tb_xmodem_1k_receiver.sv
